/* sv/owmcrc_pkg.sv */
// Package: shared types, codes and CRC/image functions for the 1-Wire memory slave.
`timescale 1ns / 1ps
`default_nettype none

package owmcrc_pkg;

  localparam int STORE_BYTES_DEF = 32;
  localparam int PAGE_BYTES_DEF  = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CMD_READ_BYTE  = 8'hAA;
  localparam logic [7:0] CMD_WRITE_BYTE = 8'h55;
  localparam logic [7:0] FILL_BYTE      = 8'hFF;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CRC_LO = 2'd1,
    KIND_CRC_HI = 2'd2,
    KIND_ECHO   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_ADDR_LO,
    PH_ADDR_HI,
    PH_DATA,
    PH_INERT
  } phase_t;

  typedef enum logic [2:0] {
    OP_CMD,
    OP_ADDR_LO,
    OP_ADDR_HI,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_RD,
    BS_RD_LO,
    BS_RD_HI,
    BS_WR_HI,
    BS_WR_ECHO,
    BS_WR_CRC
  } bstate_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } qent_t;

  // 1-Wire CRC16, reflected poly 0xA001, one byte
  function automatic logic [15:0] crc8_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // power-on contents of the store
  function automatic logic [7:0] image_byte(input logic [7:0] i);
    logic [7:0] v;
    v = 8'h00;
    if (i >= 8'd8 && i <= 8'd15) begin
      v = i[0] ? 8'h8C : 8'h08;
    end else if (i >= 8'd16 && i <= 8'd23) begin
      v = i[0] ? 8'hFF : 8'h00;
    end else if (i == 8'd28) begin
      v = 8'h40;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/owmcrc_front.sv */
// Front end: tracks the transaction phase, drops ignored words, queues operations.
`timescale 1ns / 1ps
`default_nettype none

module owmcrc_front import owmcrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] action,
  input  wire logic [7:0] bus_byte,
  input  wire logic       hold,
  input  wire logic       q_full,
  output logic            push,
  output qent_t           push_ent
);

  phase_t phase, phase_next;
  logic   cmd_rd, cmd_rd_next;
  logic   accept;

  assign in_stall = hold || q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      cmd_rd <= 1'b0;
    end else begin
      phase  <= phase_next;
      cmd_rd <= cmd_rd_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    cmd_rd_next   = cmd_rd;
    push          = 1'b0;
    push_ent.op   = OP_CMD;
    push_ent.data = bus_byte;
    if (accept) begin
      if (action == ACT_RESET) begin
        phase_next = PH_CMD;
      end else begin
        unique case (phase)
          PH_CMD: begin
            if (action == ACT_WRITE) begin
              if (bus_byte == CMD_READ_BYTE || bus_byte == CMD_WRITE_BYTE) begin
                push        = 1'b1;
                push_ent.op = OP_CMD;
                cmd_rd_next = (bus_byte == CMD_READ_BYTE);
                phase_next  = PH_ADDR_LO;
              end else begin
                phase_next = PH_INERT;
              end
            end
          end
          PH_ADDR_LO: begin
            if (action == ACT_WRITE) begin
              push        = 1'b1;
              push_ent.op = OP_ADDR_LO;
              phase_next  = PH_ADDR_HI;
            end
          end
          PH_ADDR_HI: begin
            if (action == ACT_WRITE) begin
              push        = 1'b1;
              push_ent.op = OP_ADDR_HI;
              phase_next  = PH_DATA;
            end
          end
          PH_DATA: begin
            if (cmd_rd && action == ACT_READ) begin
              push        = 1'b1;
              push_ent.op = OP_READ;
            end else if (!cmd_rd && action == ACT_WRITE) begin
              push        = 1'b1;
              push_ent.op = OP_WRITE;
            end
          end
          PH_IDLE, PH_INERT: begin
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* sv/owmcrc_queue.sv */
// Two-entry operation queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module owmcrc_queue import owmcrc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire qent_t push_ent,
  output logic       full,
  input  wire logic  pop,
  output logic       q_valid,
  output qent_t      q_ent
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);

  qent_t          slot [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_ent   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/owmcrc_back.sv */
// Back end: address, CRC16, register store and the output word register.
`timescale 1ns / 1ps
`default_nettype none

module owmcrc_back import owmcrc_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire qent_t      q_ent,
  output logic            pop,
  output logic            init_busy,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      send_byte,
  output logic [1:0]      byte_kind,
  output logic            last_of_run
);

  localparam int IW = $clog2(STORE_BYTES);

  function automatic logic [STORE_BYTES-1:0] page_end_mask();
    logic [STORE_BYTES-1:0] m;
    for (int i = 0; i < STORE_BYTES; i++) begin
      m[i] = ((i % PAGE_BYTES) == (PAGE_BYTES - 1));
    end
    return m;
  endfunction

  localparam logic [STORE_BYTES-1:0] PAGE_END_MASK = page_end_mask();

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_q;
  logic [IW-1:0] init_cnt;

  bstate_t       state, state_next;
  logic [15:0]   addr, addr_next;
  logic [15:0]   crc, crc_next;
  logic [7:0]    wbyte, wbyte_next;
  logic          ov_next, last_next;
  logic [7:0]    sb_next;
  logic [1:0]    kind_next;
  logic          mem_we;

  logic [IW-1:0] idx;
  logic          in_range, page_end, out_free;
  logic [15:0]   addr_inc, crc_c;

  assign idx      = addr[IW-1:0];
  assign in_range = (addr < 16'(STORE_BYTES));
  assign page_end = PAGE_END_MASK[idx];
  assign out_free = !out_valid || !out_stall;
  assign addr_inc = addr + 16'd1;

  // store: image load after reset, then byte writes
  always_ff @(posedge clk) begin
    if (init_busy) begin
      mem[init_cnt] <= image_byte(8'(init_cnt));
    end else if (mem_we) begin
      mem[idx] <= wbyte;
    end
    mem_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_cnt  <= '0;
    end else if (init_busy) begin
      if (init_cnt == IW'(STORE_BYTES - 1)) begin
        init_busy <= 1'b0;
      end
      init_cnt <= init_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      addr      <= '0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      addr      <= addr_next;
      crc       <= crc_next;
      out_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    wbyte       <= wbyte_next;
    send_byte   <= sb_next;
    byte_kind   <= kind_next;
    last_of_run <= last_next;
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    crc_next   = crc;
    wbyte_next = wbyte;
    ov_next    = out_valid && out_stall;
    sb_next    = send_byte;
    kind_next  = byte_kind;
    last_next  = last_of_run;
    pop        = 1'b0;
    mem_we     = 1'b0;
    crc_c      = crc8_add(crc, q_ent.data);
    unique case (state)
      BS_IDLE: begin
        if (q_valid) begin
          unique case (q_ent.op)
            OP_CMD: begin
              pop      = 1'b1;
              crc_next = crc8_add(16'h0000, q_ent.data);
            end
            OP_ADDR_LO: begin
              pop       = 1'b1;
              addr_next = {8'h00, q_ent.data};
              crc_next  = crc_c;
            end
            OP_ADDR_HI: begin
              pop       = 1'b1;
              addr_next = {q_ent.data, addr[7:0]};
              crc_next  = crc_c;
            end
            OP_READ: begin
              pop        = 1'b1;
              state_next = BS_RD;
            end
            OP_WRITE: begin
              if (out_free) begin
                pop        = 1'b1;
                crc_next   = crc_c;
                wbyte_next = q_ent.data;
                ov_next    = 1'b1;
                sb_next    = ~crc_c[7:0];
                kind_next  = KIND_CRC_LO;
                last_next  = 1'b0;
                state_next = BS_WR_HI;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      BS_RD: begin
        // mem_q holds the byte at addr here
        if (out_free) begin
          ov_next = 1'b1;
          if (!in_range) begin
            sb_next    = FILL_BYTE;
            kind_next  = KIND_ECHO;
            last_next  = 1'b1;
            state_next = BS_IDLE;
          end else begin
            sb_next   = mem_q;
            kind_next = KIND_DATA;
            last_next = !page_end;
            crc_next  = crc8_add(crc, mem_q);
            if (page_end) begin
              state_next = BS_RD_LO;
            end else begin
              addr_next  = addr_inc;
              state_next = BS_IDLE;
            end
          end
        end
      end
      BS_RD_LO: begin
        if (out_free) begin
          ov_next    = 1'b1;
          sb_next    = ~crc[7:0];
          kind_next  = KIND_CRC_LO;
          last_next  = 1'b0;
          state_next = BS_RD_HI;
        end
      end
      BS_RD_HI: begin
        if (out_free) begin
          ov_next    = 1'b1;
          sb_next    = ~crc[15:8];
          kind_next  = KIND_CRC_HI;
          last_next  = 1'b1;
          crc_next   = '0;
          addr_next  = addr_inc;
          state_next = BS_IDLE;
        end
      end
      BS_WR_HI: begin
        if (out_free) begin
          ov_next    = 1'b1;
          sb_next    = ~crc[15:8];
          kind_next  = KIND_CRC_HI;
          last_next  = 1'b0;
          mem_we     = in_range;
          state_next = BS_WR_ECHO;
        end
      end
      BS_WR_ECHO: begin
        if (out_free) begin
          ov_next    = 1'b1;
          sb_next    = wbyte;
          kind_next  = KIND_ECHO;
          last_next  = 1'b1;
          addr_next  = addr_inc;
          crc_next   = crc8_add(16'h0000, addr_inc[7:0]);
          state_next = BS_WR_CRC;
        end
      end
      BS_WR_CRC: begin
        crc_next   = crc8_add(crc, addr[15:8]);
        state_next = BS_IDLE;
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/onewire_memory_slave_crc16.sv */
// Top level: 1-Wire memory slave with CRC16, front end, op queue and back end.
// Byte-level slave for read (0xAA) and write (0x55) memory commands with the 1-Wire
// CRC16. The front end takes one input word per cycle while its two-entry op queue
// has room; ignored words (wrong direction, unknown command, idle) reach nothing
// else. The back end sets the pace: an address or command byte only updates the
// address and CRC, a read sends the data byte (and the inverted CRC, low then high,
// at a page end), a write sends CRC low, CRC high and echo, then restarts the CRC
// over the new address. Result words leave through a single output register, so
// the front keeps accepting while a result waits. After reset the store is loaded
// with its power-on image, one byte a cycle, during which in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module onewire_memory_slave_crc16 import owmcrc_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] action,
  input  wire logic [7:0] bus_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      send_byte,
  output logic [1:0]      byte_kind,
  output logic            last_of_run
);

  logic  push, pop, q_full, q_valid, init_busy;
  qent_t push_ent, q_ent;

  owmcrc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .bus_byte (bus_byte),
    .hold     (init_busy),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  owmcrc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_ent    (q_ent)
  );

  owmcrc_back #(
    .STORE_BYTES (STORE_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ent       (q_ent),
    .pop         (pop),
    .init_busy   (init_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .send_byte   (send_byte),
    .byte_kind   (byte_kind),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the 1-Wire memory slave: directed table, random transactions, scoreboard.
`timescale 1ns / 1ps

module tb_top import owmcrc_pkg::*;;

  localparam int STORE_BYTES    = STORE_BYTES_DEF;
  localparam int PAGE_BYTES     = PAGE_BYTES_DEF;
  localparam int RANDOM_ITEMS   = 350;
  localparam int CALM_ITEMS     = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam logic [7:0] CONVERT_BYTE = 8'h3C;

  typedef enum logic [1:0] {CC_NONE, CC_READ, CC_WRITE, CC_OTHER} cmd_code_t;

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
    logic       last;
  } out_word_t;

  // typed rows carry their expected word (at most one); the rest go through the predictor
  typedef struct packed {
    action_t    act;
    logic [7:0] data;
    logic       typed;
    logic       one_word;
    logic [7:0] word_val;
    kind_t      word_kind;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  action_t    action = ACT_RESET;
  logic [7:0] bus_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] send_byte;
  logic [1:0] byte_kind;
  logic       last_of_run;

  // predictor state
  logic [7:0]  mem_shadow [STORE_BYTES];
  phase_t      ph = PH_IDLE;
  cmd_code_t   cmd = CC_NONE;
  logic [15:0] cur_addr = '0;
  logic [15:0] crc_acc = '0;

  out_word_t pending_bytes[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        recv_bursty = 1'b1;
  bit        sender_bursty = 1'b1;
  bit        calm = 1'b0;

  onewire_memory_slave_crc16 u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .bus_byte    (bus_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .send_byte   (send_byte),
    .byte_kind   (byte_kind),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 1-Wire CRC16, bit-serial form (reflected 0xA001)
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) c = c ^ 16'hA001;
    end
    return c;
  endfunction

  function automatic out_word_t make_word(input logic [7:0] v, input kind_t k);
    out_word_t w;
    w.value = v;
    w.kind  = k;
    w.last  = 1'b0;
    return w;
  endfunction

  // Advances the predictor by one word; returns 0 when the block ignores it.
  function automatic bit slave_response(input action_t act, input logic [7:0] b,
                                        input bit record);
    out_word_t   words[$];
    logic [15:0] inv;
    logic [7:0]  d;
    if (act == ACT_RESET) begin
      ph      = PH_CMD;
      cmd     = CC_NONE;
      crc_acc = '0;
      return 1'b1;
    end
    if (act == ACT_NONE) return 1'b0;
    case (ph)
      PH_CMD: begin
        if (act != ACT_WRITE) return 1'b0;
        crc_acc = '0;
        if (b == CMD_READ_BYTE || b == CMD_WRITE_BYTE) begin
          cmd     = (b == CMD_READ_BYTE) ? CC_READ : CC_WRITE;
          crc_acc = crc16_update(crc_acc, b);
          ph      = PH_ADDR_LO;
        end else begin
          cmd = CC_OTHER;
          ph  = PH_INERT;
        end
        return 1'b1;
      end
      PH_ADDR_LO: begin
        if (act != ACT_WRITE) return 1'b0;
        cur_addr = {8'h00, b};
        crc_acc  = crc16_update(crc_acc, b);
        ph       = PH_ADDR_HI;
        return 1'b1;
      end
      PH_ADDR_HI: begin
        if (act != ACT_WRITE) return 1'b0;
        cur_addr[15:8] = b;
        crc_acc        = crc16_update(crc_acc, b);
        ph             = PH_DATA;
        return 1'b1;
      end
      PH_DATA: begin
        if (cmd == CC_READ && act == ACT_READ) begin
          if (cur_addr >= STORE_BYTES) begin
            // past the end: filler, address and CRC hold
            words.push_back(make_word(FILL_BYTE, KIND_ECHO));
          end else begin
            d = mem_shadow[cur_addr];
            words.push_back(make_word(d, KIND_DATA));
            crc_acc = crc16_update(crc_acc, d);
            if (cur_addr % PAGE_BYTES == PAGE_BYTES - 1) begin
              inv = ~crc_acc;
              words.push_back(make_word(inv[7:0], KIND_CRC_LO));
              words.push_back(make_word(inv[15:8], KIND_CRC_HI));
              crc_acc = '0;
            end
            cur_addr = cur_addr + 16'd1;
          end
        end else if (cmd == CC_WRITE && act == ACT_WRITE) begin
          crc_acc = crc16_update(crc_acc, b);
          inv     = ~crc_acc;
          words.push_back(make_word(inv[7:0], KIND_CRC_LO));
          words.push_back(make_word(inv[15:8], KIND_CRC_HI));
          if (cur_addr < STORE_BYTES) mem_shadow[cur_addr] = b;
          words.push_back(make_word(b, KIND_ECHO));
          cur_addr = cur_addr + 16'd1;
          crc_acc  = crc16_update(16'h0000, cur_addr[7:0]);
          crc_acc  = crc16_update(crc_acc, cur_addr[15:8]);
        end else begin
          return 1'b0;
        end
      end
      default: return 1'b0;
    endcase
    words[words.size() - 1].last = 1'b1;
    if (record) foreach (words[i]) pending_bytes.push_back(words[i]);
    return 1'b1;
  endfunction

  // occasionally swap in a random action to break the sequence
  function automatic action_t noisy(input action_t want);
    if ($urandom_range(0, 11) == 0) return action_t'($urandom_range(0, 3));
    return want;
  endfunction

  task automatic send_word(input action_t act, input logic [7:0] b, input bit use_model);
    if (!calm && sender_bursty && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    bus_byte <= b;
    do @(posedge clk); while (in_stall);
    void'(slave_response(act, b, use_model));
  endtask

  // result side: random stall bursts, none once the run is calm
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) recv_bursty = !recv_bursty;
    if (calm) stall_left = 0;
    else if (stall_left > 0) stall_left = stall_left - 1;
    else if (recv_bursty && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected word: send_byte %h byte_kind %0d last_of_run %b",
               send_byte, byte_kind, last_of_run);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (send_byte !== want.value) begin
          $error("send_byte: expected %h, got %h", want.value, send_byte);
          mismatches++;
        end
        if (byte_kind !== want.kind) begin
          $error("byte_kind: expected %0d, got %0d", want.kind, byte_kind);
          mismatches++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    directed_rows[$];
    out_word_t   typed_word;
    bit          paused;
    int          random_sent;
    int          ops;
    logic [7:0]  cmd_byte;
    logic [15:0] addr;
    action_t     body_act;

    // power-on image
    for (int i = 0; i < STORE_BYTES; i++) mem_shadow[i] = 8'h00;
    for (int i = 8; i < 16 && i < STORE_BYTES; i++) mem_shadow[i] = i[0] ? 8'h8C : 8'h08;
    for (int i = 16; i < 24 && i < STORE_BYTES; i++) mem_shadow[i] = i[0] ? 8'hFF : 8'h00;
    if (STORE_BYTES > 28) mem_shadow[28] = 8'h40;

    directed_rows = '{
      '{ACT_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, KIND_DATA},      // idle: ignored
      '{ACT_READ,  8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_NONE,  8'hFF, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_RESET, 8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_READ,  8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},      // read while command due
      '{ACT_WRITE, CMD_READ_BYTE, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'h0E, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_READ,  8'h00, 1'b1, 1'b1, 8'h08, KIND_DATA},
      '{ACT_WRITE, CMD_WRITE_BYTE, 1'b1, 1'b0, 8'h00, KIND_DATA}, // wrong direction
      '{ACT_READ,  8'h00, 1'b0, 1'b0, 8'h00, KIND_DATA},      // page end, CRC follows
      '{ACT_RESET, 8'hFF, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, CMD_READ_BYTE, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'h1F, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_READ,  8'h00, 1'b0, 1'b0, 8'h00, KIND_DATA},      // last byte of store
      '{ACT_READ,  8'h00, 1'b1, 1'b1, FILL_BYTE, KIND_ECHO},  // past the end
      '{ACT_RESET, 8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, CMD_WRITE_BYTE, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'hA5, 1'b0, 1'b0, 8'h00, KIND_DATA},      // out of range, address wraps
      '{ACT_WRITE, 8'h5A, 1'b0, 1'b0, 8'h00, KIND_DATA},      // lands at address 0
      '{ACT_RESET, 8'h00, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, CONVERT_BYTE, 1'b1, 1'b0, 8'h00, KIND_DATA},
      '{ACT_WRITE, 8'h12, 1'b1, 1'b0, 8'h00, KIND_DATA}       // silent after convert
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].act, directed_rows[i].data, !directed_rows[i].typed);
      if (directed_rows[i].typed && directed_rows[i].one_word) begin
        typed_word       = make_word(directed_rows[i].word_val, directed_rows[i].word_kind);
        typed_word.last  = 1'b1;
        pending_bytes.push_back(typed_word);
      end
    end

    random_sent = 0;
    paused      = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      calm          = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
      sender_bursty = ($urandom_range(0, 2) != 0);
      if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
        // hold off until every pending word has drained
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
      end

      send_word(ACT_RESET, 8'($urandom), 1'b1);
      random_sent++;

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: cmd_byte = CMD_READ_BYTE;
        5, 6, 7, 8:    cmd_byte = CMD_WRITE_BYTE;
        default:       cmd_byte = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0, 1:    addr = 16'($urandom_range(0, STORE_BYTES - 1));
        2:       addr = 16'($urandom_range(STORE_BYTES - 3, STORE_BYTES + 2));
        default: addr = 16'($urandom);
      endcase

      send_word(noisy(ACT_WRITE), cmd_byte, 1'b1);
      random_sent++;
      send_word(noisy(ACT_WRITE), addr[7:0], 1'b1);
      random_sent++;
      send_word(noisy(ACT_WRITE), addr[15:8], 1'b1);
      random_sent++;

      body_act = (cmd_byte == CMD_READ_BYTE) ? ACT_READ : ACT_WRITE;
      ops = $urandom_range(1, 14);
      for (int k = 0; k < ops; k++) begin
        send_word(noisy(body_act), 8'($urandom), 1'b1);
        random_sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
